### rtl/bmt_pkg.sv
// ----------------------------------------------------------------------------
// bmt_pkg: shared types and constants of the bracket matching tokenizer
// Result kinds, status codes, command characters, the record passed from the
// front to the back through the queue, and a 16-bit saturation helper.
// ----------------------------------------------------------------------------
package bmt_pkg;

	// result kinds
	localparam logic [2:0] K_MOVE       = 3'd0;
	localparam logic [2:0] K_CHANGE     = 3'd1;
	localparam logic [2:0] K_OUTPUT     = 3'd2;
	localparam logic [2:0] K_INPUT      = 3'd3;
	localparam logic [2:0] K_LOOP_START = 3'd4;
	localparam logic [2:0] K_LOOP_END   = 3'd5;
	localparam logic [2:0] K_PATCH      = 3'd6;
	localparam logic [2:0] K_DONE       = 3'd7;

	// status codes
	localparam logic [2:0] ST_OK              = 3'd0;
	localparam logic [2:0] ST_UNMATCHED_CLOSE = 3'd1;
	localparam logic [2:0] ST_UNMATCHED_OPEN  = 3'd2;
	localparam logic [2:0] ST_NEST_OVERFLOW   = 3'd3;
	localparam logic [2:0] ST_TOO_LONG        = 3'd4;

	// source characters
	localparam logic [7:0] CH_RIGHT   = 8'h3E; // '>'
	localparam logic [7:0] CH_LEFT    = 8'h3C; // '<'
	localparam logic [7:0] CH_PLUS    = 8'h2B; // '+'
	localparam logic [7:0] CH_MINUS   = 8'h2D; // '-'
	localparam logic [7:0] CH_DOT     = 8'h2E; // '.'
	localparam logic [7:0] CH_COMMA   = 8'h2C; // ','
	localparam logic [7:0] CH_OPEN    = 8'h5B; // '['
	localparam logic [7:0] CH_CLOSE   = 8'h5D; // ']'
	localparam logic [7:0] CH_NEWLINE = 8'h0A;

	// front-to-back queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QAW         = $clog2(QUEUE_DEPTH);

	// everything one source byte produces, up to three results
	typedef struct packed {
		logic               has_patch;
		logic               has_cmd;
		logic               has_done;
		logic [2:0]         cmd_kind;
		logic [2:0]         cmd_status;
		logic [15:0]        cmd_pos;
		logic signed [16:0] cmd_amt;
		logic [15:0]        line;
		logic [15:0]        col;
		logic [15:0]        patch_pos;
		logic [16:0]        patch_off;
		logic [15:0]        patch_line;
		logic [15:0]        patch_col;
		logic [15:0]        done_pos;
		logic [15:0]        done_line;
		logic [15:0]        done_col;
		logic [2:0]         done_status;
	} rec_t;

	// clamp an unsigned value to 65535
	function automatic logic [15:0] sat16(input logic [32:0] v);
		logic [15:0] r;
		r = (v > 33'd65535) ? 16'hFFFF : v[15:0];
		return r;
	endfunction

endpackage

### rtl/bmt_src_if.sv
// ----------------------------------------------------------------------------
// bmt_src_if: source byte channel
// One source byte per transaction with its end-of-source mark.
// ----------------------------------------------------------------------------
interface bmt_src_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_source;

	modport source (output valid, output ch, output end_of_source, input ready);
	modport sink (input valid, input ch, input end_of_source, output ready);
endinterface

### rtl/bmt_res_if.sv
// ----------------------------------------------------------------------------
// bmt_res_if: result channel
// One instruction, patch or done result per transaction.
// ----------------------------------------------------------------------------
interface bmt_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [15:0]        position;
	logic signed [16:0] amount;
	logic [15:0]        src_line;
	logic [15:0]        src_column;
	logic [2:0]         status;
	logic               last;

	modport source (output valid, output kind, output position, output amount,
		output src_line, output src_column, output status, output last, input ready);
	modport sink (input valid, input kind, input position, input amount,
		input src_line, input src_column, input status, input last, output ready);
endinterface

### rtl/bmt_front.sv
// ----------------------------------------------------------------------------
// bmt_front: byte classifier, location tracker and loop stack
// Accepts one byte per cycle while the queue is not full, updates line, column,
// position and the open loop stack, and queues one record per result-producing byte.
// ----------------------------------------------------------------------------
module bmt_front
	import bmt_pkg::*;
#(
	parameter int STACK_DEPTH   = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	bmt_src_if.sink   src,
	input  logic      q_full,
	output logic      q_push,
	output rec_t      q_rec
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int NW = POSITION_BITS + 1;

	typedef struct packed {
		logic [POSITION_BITS-1:0] pos;
		logic [15:0]              line;
		logic [15:0]              col;
	} entry_t;

	logic [CW-1:0] count_q;
	logic [NW-1:0] next_pos_q;
	logic [15:0]   line_q;
	logic [15:0]   col_q;
	logic [2:0]    halt_q;
	logic          fresh_q;
	entry_t        byp_top_q;
	entry_t        byp_below_q;
	entry_t        rd_top_q;
	entry_t        rd_below_q;
	entry_t        mem [STACK_DEPTH];

	logic               accept;
	logic               is_cmd;
	logic [2:0]         kind;
	logic signed [16:0] step_amt;
	logic               active;
	logic [2:0]         err;
	logic               do_push;
	logic               do_pop;
	logic               do_adv;
	entry_t             top;
	entry_t             below;
	entry_t             new_entry;
	entry_t             done_entry;
	logic [32:0]        off;
	logic [15:0]        off_sat;
	logic [NW-1:0]      next_pos_n;
	logic [CW-1:0]      count_n;
	logic [CW-1:0]      count_nx;
	logic [2:0]         halt_n;
	logic [CW-1:0]      rd_a;
	logic [CW-1:0]      rd_b;

	assign src.ready = !q_full;
	assign accept    = src.valid && src.ready;

	// decode the command byte
	always_comb begin
		is_cmd   = 1'b1;
		kind     = K_OUTPUT;
		step_amt = 17'sd0;
		case (src.ch)
			CH_RIGHT: begin kind = K_MOVE;       step_amt = 17'sd1;  end
			CH_LEFT:  begin kind = K_MOVE;       step_amt = -17'sd1; end
			CH_PLUS:  begin kind = K_CHANGE;     step_amt = 17'sd1;  end
			CH_MINUS: begin kind = K_CHANGE;     step_amt = -17'sd1; end
			CH_DOT:   kind = K_OUTPUT;
			CH_COMMA: kind = K_INPUT;
			CH_OPEN:  kind = K_LOOP_START;
			CH_CLOSE: kind = K_LOOP_END;
			default:  is_cmd = 1'b0;
		endcase
	end

	// top two stack entries: bypass right after a push, else registered reads
	assign top   = fresh_q ? byp_top_q : rd_top_q;
	assign below = fresh_q ? byp_below_q : rd_below_q;

	// error checks and stack operation
	always_comb begin
		active = (halt_q == ST_OK) && is_cmd;
		if (kind == K_LOOP_END && count_q == '0)
			err = ST_UNMATCHED_CLOSE;
		else if (next_pos_q[POSITION_BITS])
			err = ST_TOO_LONG;
		else if (kind == K_LOOP_START && count_q == CW'(STACK_DEPTH))
			err = ST_NEST_OVERFLOW;
		else
			err = ST_OK;
		do_adv  = active && (err == ST_OK);
		do_push = do_adv && (kind == K_LOOP_START);
		do_pop  = do_adv && (kind == K_LOOP_END);
		halt_n  = active ? err : halt_q;
		next_pos_n = do_adv ? next_pos_q + NW'(1) : next_pos_q;
		if (do_push)
			count_n = count_q + CW'(1);
		else if (do_pop)
			count_n = count_q - CW'(1);
		else
			count_n = count_q;
		new_entry = '{pos: next_pos_q[POSITION_BITS-1:0], line: line_q, col: col_q};
		off     = 33'(next_pos_q) - 33'(top.pos);
		off_sat = sat16(off);
	end

	// build the record
	always_comb begin
		if (do_push)
			done_entry = new_entry;
		else if (do_pop)
			done_entry = below;
		else
			done_entry = top;

		q_rec            = '0;
		q_rec.has_cmd    = active;
		q_rec.has_patch  = do_pop;
		q_rec.has_done   = src.end_of_source;
		q_rec.cmd_kind   = kind;
		q_rec.cmd_status = err;
		q_rec.cmd_pos    = sat16(33'(next_pos_q));
		q_rec.line       = line_q;
		q_rec.col        = col_q;
		if (err != ST_OK || do_push)
			q_rec.cmd_amt = 17'sd0;
		else if (do_pop)
			q_rec.cmd_amt = -$signed({1'b0, off_sat});
		else
			q_rec.cmd_amt = step_amt;
		q_rec.patch_pos  = sat16(33'(top.pos));
		q_rec.patch_off  = {1'b0, off_sat};
		q_rec.patch_line = top.line;
		q_rec.patch_col  = top.col;
		if (halt_n == ST_OK && count_n != '0) begin
			q_rec.done_pos    = sat16(33'(done_entry.pos));
			q_rec.done_line   = done_entry.line;
			q_rec.done_col    = done_entry.col;
			q_rec.done_status = ST_UNMATCHED_OPEN;
		end else begin
			q_rec.done_pos    = sat16(33'(next_pos_n));
			q_rec.done_line   = line_q;
			q_rec.done_col    = col_q;
			q_rec.done_status = halt_n;
		end
	end

	assign q_push = accept && (active || src.end_of_source);

	// count after this cycle, used to prefetch the top two entries
	always_comb begin
		if (accept)
			count_nx = src.end_of_source ? '0 : count_n;
		else
			count_nx = count_q;
		rd_a = count_nx - CW'(1);
		rd_b = count_nx - CW'(2);
	end

	// stack memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (accept && do_push)
			mem[count_q[AW-1:0]] <= new_entry;
		rd_top_q   <= mem[rd_a[AW-1:0]];
		rd_below_q <= mem[rd_b[AW-1:0]];
	end

	// hold bypass copies of the top two entries after a push
	always_ff @(posedge clk) begin
		if (accept && do_push) begin
			byp_top_q   <= new_entry;
			byp_below_q <= top;
		end
	end

	// advance location, position, stack count and halt state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			next_pos_q <= '0;
			line_q     <= 16'd1;
			col_q      <= 16'd1;
			halt_q     <= ST_OK;
			fresh_q    <= 1'b0;
		end else if (accept) begin
			if (src.end_of_source) begin
				count_q    <= '0;
				next_pos_q <= '0;
				line_q     <= 16'd1;
				col_q      <= 16'd1;
				halt_q     <= ST_OK;
				fresh_q    <= 1'b0;
			end else begin
				count_q    <= count_n;
				next_pos_q <= next_pos_n;
				halt_q     <= halt_n;
				fresh_q    <= do_push;
				if (src.ch == CH_NEWLINE) begin
					if (line_q != 16'hFFFF)
						line_q <= line_q + 16'd1;
					col_q <= 16'd1;
				end else if (col_q != 16'hFFFF) begin
					col_q <= col_q + 16'd1;
				end
			end
		end
	end

endmodule

### rtl/bmt_queue.sv
// ----------------------------------------------------------------------------
// bmt_queue: record queue between front and back
// Small show-ahead queue; the head record is visible while not empty.
// ----------------------------------------------------------------------------
module bmt_queue
	import bmt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t push_rec,
	output logic full,
	input  logic pop,
	output rec_t head_rec,
	output logic empty
);

	rec_t         slot_q [QUEUE_DEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   fill_q;

	assign full     = (fill_q == (QAW + 1)'(QUEUE_DEPTH));
	assign empty    = (fill_q == '0);
	assign head_rec = slot_q[rd_ptr_q];

	// store records
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_rec;
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			if (push && !pop)
				fill_q <= fill_q + (QAW + 1)'(1);
			else if (pop && !push)
				fill_q <= fill_q - (QAW + 1)'(1);
		end
	end

endmodule

### rtl/bmt_back.sv
// ----------------------------------------------------------------------------
// bmt_back: result sequencer
// Expands the head record into its patch, instruction and done results,
// one per cycle while res is not stalled, into the output register.
// ----------------------------------------------------------------------------
module bmt_back
	import bmt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  rec_t      rec,
	input  logic      empty,
	output logic      pop,
	bmt_res_if.source res
);

	logic               out_valid_q;
	logic               sent_patch_q;
	logic               sent_cmd_q;
	logic [2:0]         kind_q;
	logic [15:0]        position_q;
	logic signed [16:0] amount_q;
	logic [15:0]        line_q;
	logic [15:0]        col_q;
	logic [2:0]         status_q;
	logic               last_q;

	logic sel_patch;
	logic sel_cmd;
	logic is_last;
	logic load;

	// pick the next result of the head record
	always_comb begin
		sel_patch = rec.has_patch && !sent_patch_q;
		sel_cmd   = !sel_patch && rec.has_cmd && !sent_cmd_q;
		if (sel_patch)
			is_last = !rec.has_cmd && !rec.has_done;
		else if (sel_cmd)
			is_last = !rec.has_done;
		else
			is_last = 1'b1;
		load = !empty && (!out_valid_q || res.ready);
		pop  = load && is_last;
	end

	assign res.valid      = out_valid_q;
	assign res.kind       = kind_q;
	assign res.position   = position_q;
	assign res.amount     = amount_q;
	assign res.src_line   = line_q;
	assign res.src_column = col_q;
	assign res.status     = status_q;
	assign res.last       = last_q;

	// output valid and progress through the record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			sent_patch_q <= 1'b0;
			sent_cmd_q   <= 1'b0;
		end else begin
			if (load)
				out_valid_q <= 1'b1;
			else if (res.ready)
				out_valid_q <= 1'b0;
			if (load) begin
				if (is_last) begin
					sent_patch_q <= 1'b0;
					sent_cmd_q   <= 1'b0;
				end else if (sel_patch) begin
					sent_patch_q <= 1'b1;
				end else if (sel_cmd) begin
					sent_cmd_q <= 1'b1;
				end
			end
		end
	end

	// load the output payload
	always_ff @(posedge clk) begin
		if (load) begin
			last_q <= is_last;
			if (sel_patch) begin
				kind_q     <= K_PATCH;
				position_q <= rec.patch_pos;
				amount_q   <= $signed(rec.patch_off);
				line_q     <= rec.patch_line;
				col_q      <= rec.patch_col;
				status_q   <= ST_OK;
			end else if (sel_cmd) begin
				kind_q     <= rec.cmd_kind;
				position_q <= rec.cmd_pos;
				amount_q   <= rec.cmd_amt;
				line_q     <= rec.line;
				col_q      <= rec.col;
				status_q   <= rec.cmd_status;
			end else begin
				kind_q     <= K_DONE;
				position_q <= rec.done_pos;
				amount_q   <= 17'sd0;
				line_q     <= rec.done_line;
				col_q      <= rec.done_col;
				status_q   <= rec.done_status;
			end
		end
	end

endmodule

### rtl/bracket_matching_tokenizer.sv
// ----------------------------------------------------------------------------
// bracket_matching_tokenizer: tape-language tokenizer with loop matching
// Classifies source bytes, tracks location and open loops, and emits
// instructions, loop patches and a done result at end of source.
// ----------------------------------------------------------------------------
//  channel  dir  transaction        payload
//  src      in   one source byte    ch, end_of_source
//  res      out  one result         kind, position, amount, src_line,
//                                   src_column, status, last
//
//  The front accepts one byte per cycle while the four-entry record queue has
//  room; a byte's record is registered in the queue, then in the back's output register.
//  The back sends one result per cycle while res is ready: a closing bracket gives
//  a patch and a loop end, plus a done result at end, so sustained rate follows the result count.
//  Reset returns line and column to 1 and clears position, stack and halt.
//  A stall on res fills the queue, then drops src.ready; neither side loses data.
// ----------------------------------------------------------------------------
module bracket_matching_tokenizer
	import bmt_pkg::*;
#(
	parameter int STACK_DEPTH   = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	bmt_src_if.sink   src,
	bmt_res_if.source res
);

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_empty;
	rec_t push_rec;
	rec_t head_rec;

	bmt_front #(
		.STACK_DEPTH  (STACK_DEPTH),
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.src   (src),
		.q_full(q_full),
		.q_push(q_push),
		.q_rec (push_rec)
	);

	bmt_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_rec(push_rec),
		.full    (q_full),
		.pop     (q_pop),
		.head_rec(head_rec),
		.empty   (q_empty)
	);

	bmt_back u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.rec   (head_rec),
		.empty (q_empty),
		.pop   (q_pop),
		.res   (res)
	);

endmodule

### verif/bmt_token_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmt_token_checker: result predictor and comparator for the tokenizer
// Watches both channels. Every accepted source byte runs through a local
// model of the tokenizer, and the results it should cause are queued.
// Every accepted result is compared with the oldest queued one.
// ----------------------------------------------------------------------------
module bmt_token_checker
	import bmt_pkg::*;
#(
	parameter int STACK_DEPTH   = 64,
	parameter int POSITION_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	bmt_src_if   src,
	bmt_res_if   res,
	output int   fail_count,
	output int   pending_count
);

	localparam int POS_LIMIT = 1 << POSITION_BITS;
	localparam int SAT       = 65535;
	localparam int MAX_SHOWN = 10;

	typedef struct packed {
		logic [2:0]         kind;
		logic [15:0]        position;
		logic signed [16:0] amount;
		logic [15:0]        src_line;
		logic [15:0]        src_column;
		logic [2:0]         status;
		logic               last;
	} token_t;

	// model state: open loops, position counter, location, halt code
	int         open_pos  [STACK_DEPTH];
	int         open_line [STACK_DEPTH];
	int         open_col  [STACK_DEPTH];
	int         open_count;
	int         next_pos;
	int         cur_line;
	int         cur_col;
	logic [2:0] halt_code;

	token_t expected_tokens[$];
	int     mismatch_count = 0;

	function automatic token_t build_token(input logic [2:0] k, input int pos, input int amt,
			input int ln, input int cl, input logic [2:0] st);
		token_t t;
		int     a;
		a = amt;
		if (a > SAT)
			a = SAT;
		if (a < -SAT)
			a = -SAT;
		t.kind       = k;
		t.position   = (pos > SAT) ? 16'hFFFF : 16'(pos);
		t.amount     = 17'(a);
		t.src_line   = 16'(ln);
		t.src_column = 16'(cl);
		t.status     = st;
		t.last       = 1'b0;
		return t;
	endfunction

	// format the fields of one result for a report line
	function automatic string describe(input token_t t);
		return $sformatf("kind %0d pos %0d amt %0d line %0d col %0d status %0d last %0b",
			t.kind, t.position, t.amount, t.src_line, t.src_column, t.status, t.last);
	endfunction

	task automatic clear_tokenizer();
		open_count = 0;
		next_pos   = 0;
		cur_line   = 1;
		cur_col    = 1;
		halt_code  = ST_OK;
	endtask

	// work out every result one source byte causes and queue them in order
	task automatic predict_tokens(input logic [7:0] c, input logic eos);
		token_t     batch[$];
		logic [2:0] k;
		logic [2:0] err;
		int         amt;
		bit         is_cmd;
		int         ln;
		int         cl;
		int         top;
		int         off;
		ln = cur_line;
		cl = cur_col;
		// advance location, saturating
		if (c == CH_NEWLINE) begin
			if (cur_line < SAT)
				cur_line++;
			cur_col = 1;
		end else if (cur_col < SAT) begin
			cur_col++;
		end
		// classify the byte
		k      = K_MOVE;
		amt    = 0;
		is_cmd = 1'b1;
		case (c)
			CH_RIGHT: begin k = K_MOVE; amt = 1; end
			CH_LEFT: begin k = K_MOVE; amt = -1; end
			CH_PLUS: begin k = K_CHANGE; amt = 1; end
			CH_MINUS: begin k = K_CHANGE; amt = -1; end
			CH_DOT: k = K_OUTPUT;
			CH_COMMA: k = K_INPUT;
			CH_OPEN: k = K_LOOP_START;
			CH_CLOSE: k = K_LOOP_END;
			default: is_cmd = 1'b0;
		endcase
		// emit the instruction unless halted
		if (halt_code == ST_OK && is_cmd) begin
			err = ST_OK;
			if (k == K_LOOP_END && open_count == 0)
				err = ST_UNMATCHED_CLOSE;
			else if (next_pos >= POS_LIMIT)
				err = ST_TOO_LONG;
			else if (k == K_LOOP_START && open_count >= STACK_DEPTH)
				err = ST_NEST_OVERFLOW;
			if (err != ST_OK) begin
				batch = {batch, build_token(k, next_pos, 0, ln, cl, err)};
				halt_code = err;
			end else if (k == K_LOOP_START) begin
				open_pos[open_count]  = next_pos;
				open_line[open_count] = ln;
				open_col[open_count]  = cl;
				open_count++;
				batch = {batch, build_token(K_LOOP_START, next_pos, 0, ln, cl, ST_OK)};
				next_pos++;
			end else if (k == K_LOOP_END) begin
				top        = open_count - 1;
				off        = next_pos - open_pos[top];
				open_count = top;
				batch = {batch, build_token(K_PATCH, open_pos[top], off, open_line[top],
					open_col[top], ST_OK)};
				batch = {batch, build_token(K_LOOP_END, next_pos, -off, ln, cl, ST_OK)};
				next_pos++;
			end else begin
				batch = {batch, build_token(k, next_pos, amt, ln, cl, ST_OK)};
				next_pos++;
			end
		end
		// close the text with a done result, then start over
		if (eos) begin
			if (halt_code == ST_OK && open_count > 0) begin
				top = open_count - 1;
				batch = {batch, build_token(K_DONE, open_pos[top], 0, open_line[top],
					open_col[top], ST_UNMATCHED_OPEN)};
			end else begin
				batch = {batch, build_token(K_DONE, next_pos, 0, ln, cl, halt_code)};
			end
			clear_tokenizer();
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].last = 1'b1;
		expected_tokens = {expected_tokens, batch};
	endtask

	// predict on each byte transaction, compare on each result transaction
	always @(posedge clk or negedge arst_n) begin
		token_t got;
		token_t want;
		if (!arst_n) begin
			clear_tokenizer();
			expected_tokens.delete();
		end else begin
			if (src.valid && src.ready)
				predict_tokens(src.ch, src.end_of_source);
			if (res.valid && res.ready) begin
				got.kind       = res.kind;
				got.position   = res.position;
				got.amount     = res.amount;
				got.src_line   = res.src_line;
				got.src_column = res.src_column;
				got.status     = res.status;
				got.last       = res.last;
				if (expected_tokens.size() == 0) begin
					if (mismatch_count < MAX_SHOWN) begin
						$display("%0t: unexpected result", $realtime);
						$display("  expected none");
						$display("  actual   %s", describe(got));
					end
					mismatch_count++;
				end else begin
					want = expected_tokens.pop_front();
					if (got.kind !== want.kind || got.position !== want.position ||
							got.amount !== want.amount || got.src_line !== want.src_line ||
							got.src_column !== want.src_column || got.status !== want.status ||
							got.last !== want.last) begin
						if (mismatch_count < MAX_SHOWN) begin
							$display("%0t: result mismatch", $realtime);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(got));
						end
						mismatch_count++;
					end
				end
			end
		end
		pending_count = expected_tokens.size();
		fail_count    = mismatch_count + pending_count;
	end

endmodule

### verif/bracket_matching_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_matching_tokenizer_tb: self-checking bench of the tokenizer
// Feeds directed texts (every command, bracket errors and nesting overflow),
// then random texts that are mostly balanced programs, under four idle
// patterns. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module bracket_matching_tokenizer_tb
	import bmt_pkg::*;
();

	localparam int STACK_DEPTH   = 64;
	localparam int POSITION_BITS = 16;
	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 10;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int PHASE_ITEMS   = 75;

	logic clk = 1'b0;
	logic arst_n;

	bmt_src_if src_if ();
	bmt_res_if res_if ();

	int fail_count;
	int pending_count;
	int src_idle_pct  = 0;
	int res_stall_pct = 0;
	int counted_items = 0;
	int cycle_count   = 0;

	bracket_matching_tokenizer #(
		.STACK_DEPTH  (STACK_DEPTH),
		.POSITION_BITS(POSITION_BITS)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.src   (src_if),
		.res   (res_if)
	);

	bmt_token_checker #(
		.STACK_DEPTH  (STACK_DEPTH),
		.POSITION_BITS(POSITION_BITS)
	) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.src          (src_if),
		.res          (res_if),
		.fail_count   (fail_count),
		.pending_count(pending_count)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// stall the result side at the current rate
	always @(posedge clk) begin
		res_if.ready <= ($urandom_range(99) >= res_stall_pct);
	end

	// end the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_count);
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] pick_command(input int idx);
		logic [7:0] c;
		case (idx % 8)
			0: c = CH_RIGHT;
			1: c = CH_LEFT;
			2: c = CH_PLUS;
			3: c = CH_MINUS;
			4: c = CH_DOT;
			5: c = CH_COMMA;
			6: c = CH_OPEN;
			default: c = CH_CLOSE;
		endcase
		return c;
	endfunction

	// present one byte, idling first at the current rate, and hold until taken
	task automatic send_byte(input logic [7:0] c, input logic eos);
		while ($urandom_range(99) < src_idle_pct) begin
			src_if.valid <= 1'b0;
			@(posedge clk);
		end
		src_if.valid         <= 1'b1;
		src_if.ch            <= c;
		src_if.end_of_source <= eos;
		@(posedge clk);
		while (!src_if.ready)
			@(posedge clk);
		counted_items++;
	endtask

	// short texts covering each command and the bracket errors
	task automatic send_directed();
		// every command, nested loops, a newline, and a plain byte closing the text
		send_byte(CH_RIGHT, 1'b0);
		send_byte(CH_LEFT, 1'b0);
		send_byte(CH_PLUS, 1'b0);
		send_byte(CH_MINUS, 1'b0);
		send_byte(CH_DOT, 1'b0);
		send_byte(CH_COMMA, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_byte(CH_OPEN, 1'b0);
		send_byte(CH_OPEN, 1'b0);
		send_byte(CH_CLOSE, 1'b0);
		send_byte(CH_CLOSE, 1'b0);
		send_byte(8'hFF, 1'b1);
		// unmatched close on the final byte
		send_byte(CH_CLOSE, 1'b1);
		// unmatched close, then bytes while halted
		send_byte(CH_CLOSE, 1'b0);
		send_byte(CH_PLUS, 1'b0);
		send_byte(CH_NEWLINE, 1'b0);
		send_byte(CH_OPEN, 1'b1);
		// loops left open at the end
		send_byte(CH_OPEN, 1'b0);
		send_byte(CH_OPEN, 1'b0);
		send_byte(8'h00, 1'b1);
		// open bracket as the final byte
		send_byte(CH_OPEN, 1'b1);
		// close bracket as the final byte: patch, loop end and done together
		send_byte(CH_OPEN, 1'b0);
		send_byte(CH_CLOSE, 1'b1);
	endtask

	// nesting overflow, then bytes ignored while halted
	task automatic send_stress();
		for (int i = 0; i <= STACK_DEPTH; i++)
			send_byte(CH_OPEN, 1'b0);
		send_byte(CH_PLUS, 1'b1);
	endtask

	// one random text: mostly a balanced program, sometimes broken or noisy
	task automatic send_random_text();
		int         depth;
		int         len;
		int         r;
		bit         broken;
		logic [7:0] c;
		depth  = 0;
		len    = $urandom_range(16, 1);
		broken = ($urandom_range(9) == 0);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (r < 20 && depth < 6) begin
				c = CH_OPEN;
			end else if (r < 35 && depth > 0) begin
				c = CH_CLOSE;
			end else if (r < 75) begin
				c = pick_command($urandom_range(5));
			end else if (r < 85) begin
				c = CH_NEWLINE;
			end else begin
				c = 8'($urandom_range(255));
			end
			if (c == CH_OPEN)
				depth++;
			else if (c == CH_CLOSE && depth > 0)
				depth--;
			send_byte(c, 1'b0);
		end
		// close open loops unless this text is meant to be broken
		if (!broken) begin
			while (depth > 0) begin
				send_byte(CH_CLOSE, 1'b0);
				depth--;
			end
		end else if ($urandom_range(1) == 1) begin
			send_byte(CH_CLOSE, 1'b0);
		end
		if ($urandom_range(1) == 1)
			c = pick_command($urandom_range(7));
		else
			c = 8'($urandom_range(255));
		send_byte(c, 1'b1);
	endtask

	initial begin
		int target;
		arst_n               = 1'b0;
		src_if.valid         <= 1'b0;
		src_if.ch            <= '0;
		src_if.end_of_source <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// four idle patterns: none, sender, receiver, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0; res_stall_pct = 0; end
				1: begin src_idle_pct = 53; res_stall_pct = 0; end
				2: begin src_idle_pct = 0; res_stall_pct = 53; end
				default: begin src_idle_pct = 20; res_stall_pct = 20; end
			endcase
			if (ph == 0) begin
				send_directed();
				send_stress();
			end
			target = counted_items + PHASE_ITEMS;
			while (counted_items < target)
				send_random_text();
		end
		src_if.valid <= 1'b0;

		// drain outstanding results, then idle for DRAIN_CYCLES before the verdict
		do
			@(negedge clk);
		while (pending_count != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d failures, %0d results never arrived", fail_count, pending_count);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
